// ===== hw/rtl/volume_overlay_pixel_generator_assert.svh =====
// Assertion macros shared by the volume overlay RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef VOLUME_OVERLAY_PIXEL_GENERATOR_ASSERT_SVH
`define VOLUME_OVERLAY_PIXEL_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VOPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VOPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/volp_pkg.sv =====
package volp_pkg;

  typedef struct packed {
    logic [6:0] pixel_column;
    logic [7:0] pixel_row;
  } volp_in_t;

  typedef struct packed {
    logic        pixel_lit;
    logic [15:0] pixel_colour;
  } volp_out_t;

  typedef struct packed {
    logic [6:0] volume_percent;
    logic       mute_flag;
  } volp_cfg_t;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_VOLUME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MUTE   = 2'd1;

  localparam logic [6:0]  PERCENT_MAX = 7'd100;
  localparam logic [15:0] COLOUR_LIT  = 16'hFFFF;
  localparam logic [15:0] COLOUR_DARK = 16'h0000;

  localparam logic [4:0] GLYPH_PERCENT = 5'd10;
  localparam logic [4:0] GLYPH_V       = 5'd11;
  localparam logic [4:0] GLYPH_O       = 5'd12;
  localparam logic [4:0] GLYPH_L       = 5'd13;
  localparam logic [4:0] GLYPH_U       = 5'd14;
  localparam logic [4:0] GLYPH_M       = 5'd15;
  localparam logic [4:0] GLYPH_E       = 5'd16;
  localparam logic [4:0] GLYPH_T       = 5'd17;

  localparam logic [6:0] FONT [18][5] = '{
    '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
    '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
    '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
    '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
    '{7'h63, 7'h13, 7'h08, 7'h64, 7'h63}, '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
    '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
    '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F},
    '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}
  };

  localparam logic [4:0] TITLE_CODES [6] = '{
    GLYPH_V, GLYPH_O, GLYPH_L, GLYPH_U, GLYPH_M, GLYPH_E
  };

endpackage

// ===== hw/rtl/volp_cfg.sv =====
module volp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write,
  input  logic [volp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                      cfg_data,
  output volp_pkg::volp_cfg_t             cfg_q
);
  import volp_pkg::*;

  logic [6:0] percent_r, percent_nxt;
  logic       mute_r, mute_nxt;

  always_comb begin
    percent_nxt = percent_r;
    mute_nxt    = mute_r;
    if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_VOLUME: percent_nxt = (cfg_data > PERCENT_MAX) ? PERCENT_MAX : cfg_data;
        CFG_IDX_MUTE:   mute_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      percent_r <= 7'd0;
      mute_r    <= 1'b0;
    end else begin
      percent_r <= percent_nxt;
      mute_r    <= mute_nxt;
    end
  end

  assign cfg_q.volume_percent = percent_r;
  assign cfg_q.mute_flag      = mute_r;

endmodule

// ===== hw/rtl/volp_render.sv =====
module volp_render (
  input  volp_pkg::volp_in_t  pixel,
  input  volp_pkg::volp_cfg_t cfg,
  output volp_pkg::volp_out_t result
);
  import volp_pkg::*;

  logic [6:0]  x;
  logic [7:0]  y;
  logic        title_lit, value_lit, border_lit, fill_lit, lit;

  assign x = pixel.pixel_column;
  assign y = pixel.pixel_row;

  // The title is drawn at scale 2 with its first glyph at column 13.
  always_comb begin
    logic [6:0] t_rel;
    logic [2:0] t_idx;
    logic [3:0] t_within;
    logic [7:0] t_dy;
    logic [2:0] t_col;
    logic [2:0] t_row;
    t_rel = x - 7'd13;
    t_idx = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (t_rel >= 7'(k * 12)) t_idx = 3'(k);
    end
    t_within = 4'(t_rel - 7'(t_idx) * 7'd12);
    t_dy     = y - 8'd14;
    t_col    = t_within[3:1];
    t_row    = t_dy[3:1];
    title_lit = 1'b0;
    if (y >= 8'd14 && y < 8'd28 && x >= 7'd13 && t_rel < 7'd72 && t_within < 4'd10) begin
      title_lit = FONT[TITLE_CODES[t_idx]][t_col][t_row];
    end
  end

  // The value text is drawn at scale 3, centred on its own length.
  always_comb begin
    logic [14:0] v_tenprod;
    logic [3:0]  v_tens;
    logic [3:0]  v_ones;
    logic [4:0]  v_codes [4];
    logic [2:0]  v_len;
    logic [6:0]  v_x0;
    logic [6:0]  v_rel;
    logic [6:0]  v_span;
    logic [1:0]  v_idx;
    logic [4:0]  v_within;
    logic [7:0]  v_dy;
    logic [2:0]  v_col;
    logic [2:0]  v_row;
    v_tenprod = 15'(cfg.volume_percent) * 15'd205;
    v_tens    = v_tenprod[14:11];
    v_ones    = 4'(cfg.volume_percent - 7'(v_tens) * 7'd10);
    if (cfg.mute_flag) begin
      v_codes = '{GLYPH_M, GLYPH_U, GLYPH_T, GLYPH_E};
      v_len   = 3'd4;
      v_x0    = 7'd13;
    end else if (cfg.volume_percent >= PERCENT_MAX) begin
      v_codes = '{5'd1, 5'd0, 5'd0, GLYPH_PERCENT};
      v_len   = 3'd4;
      v_x0    = 7'd13;
    end else if (cfg.volume_percent >= 7'd10) begin
      v_codes = '{{1'b0, v_tens}, {1'b0, v_ones}, GLYPH_PERCENT, 5'd0};
      v_len   = 3'd3;
      v_x0    = 7'd22;
    end else begin
      v_codes = '{5'(cfg.volume_percent), GLYPH_PERCENT, 5'd0, 5'd0};
      v_len   = 3'd2;
      v_x0    = 7'd31;
    end
    v_rel  = x - v_x0;
    v_span = 7'(v_len) * 7'd18;
    v_idx  = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (v_rel >= 7'(k * 18)) v_idx = 2'(k);
    end
    v_within = 5'(v_rel - 7'(v_idx) * 7'd18);
    v_col    = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if (v_within >= 5'(k * 3)) v_col = 3'(k);
    end
    v_dy  = y - 8'd55;
    v_row = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (v_dy >= 8'(k * 3)) v_row = 3'(k);
    end
    value_lit = 1'b0;
    if (y >= 8'd55 && y < 8'd76 && x >= v_x0 && v_rel < v_span && v_within < 5'd15) begin
      value_lit = FONT[v_codes[v_idx]][v_col][v_row];
    end
  end

  always_comb begin
    logic [13:0] fill_lhs;
    logic [13:0] fill_rhs;
    border_lit = (x >= 7'd10 && x <= 7'd85 &&
                  (y == 8'd108 || y == 8'd109 || y == 8'd126 || y == 8'd127)) ||
                 (y >= 8'd108 && y <= 8'd127 &&
                  (x == 7'd10 || x == 7'd11 || x == 7'd84 || x == 7'd85));
    // The column lies within the fill when (x - 13) * 100 does not exceed 68 * percent.
    fill_lhs = 14'(x - 7'd13) * 14'd100;
    fill_rhs = 14'(cfg.volume_percent) * 14'd68;
    fill_lit = !cfg.mute_flag && y >= 8'd112 && y <= 8'd123 && x >= 7'd14 &&
               fill_lhs <= fill_rhs;
  end

  assign lit                 = title_lit || value_lit || border_lit || fill_lit;
  assign result.pixel_lit    = lit;
  assign result.pixel_colour = lit ? COLOUR_LIT : COLOUR_DARK;

endmodule

// ===== hw/rtl/volume_overlay_pixel_generator.sv =====
// Volume overlay pixel generator: each request carries one pixel coordinate of the
// 96 by 160 panel and yields one result saying whether that pixel is lit and its
// RGB565 colour. One request is taken every clock while the input is not stalled. An
// accepted request is loaded into the input register, and its result moves into the
// result register once that register is empty or its result is being taken; the glyph,
// bar and border logic lies between the two registers. A stall
// from the result side holds the result register, and the input side is stalled in the
// same cycle only when both registers are full.
// The percent and mute registers are written through the configuration port, which
// is always ready; a percent above 100 is stored as 100, and writes to other indices
// are ignored. Write them only while no request is in flight.
`include "volume_overlay_pixel_generator_assert.svh"

module volume_overlay_pixel_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  volp_pkg::volp_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output volp_pkg::volp_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [volp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data
);
  import volp_pkg::*;

  volp_cfg_t cfg_q;
  volp_out_t render_q;
  volp_in_t  s1_pix_r, s1_pix_nxt;
  logic      s1_valid_r, s1_valid_nxt;
  volp_out_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      adv1, adv2;

  assign cfg_ready = 1'b1;

  volp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_q     (cfg_q)
  );

  volp_render u_render (
    .pixel  (s1_pix_r),
    .cfg    (cfg_q),
    .result (render_q)
  );

  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    s1_valid_nxt  = adv1 ? in_valid : s1_valid_r;
    s1_pix_nxt    = (adv1 && in_valid) ? in_data : s1_pix_r;
    out_valid_nxt = adv2 ? s1_valid_r : out_valid_r;
    out_data_nxt  = (adv2 && s1_valid_r) ? render_q : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r   <= s1_pix_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VOPG_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r,
    "Input stalled while a pipeline stage was free.")
  `VOPG_ASSERT_NEXT(a_accept_fills_stage, in_valid && !in_stall, s1_valid_r,
    "Accepted request did not reach the input register.")
  `VOPG_ASSERT_NEXT(a_stage_moves_on, s1_valid_r && !out_valid_r, out_valid_r,
    "Input register did not move into an empty result register.")
  `VOPG_ASSERT_NEXT(a_percent_saturates,
    cfg_valid && cfg_ready && cfg_index == CFG_IDX_VOLUME && cfg_data > PERCENT_MAX,
    cfg_q.volume_percent == PERCENT_MAX,
    "Percent write above range was not saturated.")

endmodule

// ===== dv/volume_overlay_pixel_generator_test.sv =====
module volume_overlay_pixel_generator_test;
  import volp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 38;
  localparam int PHASE_COUNT = 26;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {CHECK_PREDICT, CHECK_DARK, CHECK_LIT} row_check_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [6:0]             reg_value;
    logic [6:0]             col;
    logic [7:0]             row;
    row_check_t             check;
  } stim_row_t;

  typedef struct packed {
    volp_in_t  coord;
    volp_out_t result;
  } pending_pixel_t;

  localparam int DIRECTED_ROWS = 33;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd0, 8'd0, CHECK_DARK},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd10, 8'd108, CHECK_LIT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd14, 8'd112, CHECK_DARK},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd13, 8'd14, CHECK_LIT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd40, 8'd60, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd127, 8'd255, CHECK_DARK},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd95, 8'd159, CHECK_DARK},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd127, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd81, 8'd115, CHECK_LIT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd82, 8'd115, CHECK_DARK},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd85, 8'd127, CHECK_LIT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd30, 8'd60, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_SPARE_LO, 7'd0, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_SPARE_HI, 7'd127, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd81, 8'd115, CHECK_LIT},
    '{ROW_WRITE, CFG_IDX_MUTE, 7'd1, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd14, 8'd112, CHECK_DARK},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd30, 8'd60, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd101, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_MUTE, 7'd126, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd81, 8'd115, CHECK_LIT},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd5, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd16, 8'd112, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd17, 8'd112, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd40, 8'd60, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd10, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd40, 8'd60, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd99, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd80, 8'd123, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd45, 8'd65, CHECK_PREDICT},
    '{ROW_WRITE, CFG_IDX_VOLUME, 7'd9, 7'd0, 8'd0, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd36, 8'd58, CHECK_PREDICT},
    '{ROW_PIXEL, CFG_IDX_VOLUME, 7'd0, 7'd30, 8'd75, CHECK_PREDICT}
  };

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  volp_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  volp_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [6:0]             cfg_data = '0;

  int             volume_level = 0;
  bit             muted = 1'b0;
  bit             quiet_stretch = 1'b0;
  int             fail_count = 0;
  int             cycle_count = 0;
  pending_pixel_t pending_pixels [$];

  volume_overlay_pixel_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit glyph_hit(logic [5:0][4:0] glyphs, int count, int x0, int y0,
                                   int scale, int x, int y);
    int rel;
    int slot;
    int cell_off;
    logic [6:0] strip;
    if (y < y0 || y >= y0 + 7 * scale || x < x0) return 1'b0;
    rel = x - x0;
    slot = rel / (6 * scale);
    cell_off = rel % (6 * scale);
    if (slot >= count || cell_off >= 5 * scale) return 1'b0;
    strip = FONT[glyphs[slot]][cell_off / scale];
    return strip[(y - y0) / scale];
  endfunction

  function automatic bit pixel_is_lit(int x, int y);
    logic [5:0][4:0] title;
    logic [5:0][4:0] digits;
    int count;
    for (int i = 0; i < 6; i++) title[i] = TITLE_CODES[i];
    if (glyph_hit(title, 6, (96 - 70) / 2, 14, 2, x, y)) return 1'b1;
    digits = '0;
    if (muted) begin
      digits[0] = GLYPH_M;
      digits[1] = GLYPH_U;
      digits[2] = GLYPH_T;
      digits[3] = GLYPH_E;
      count = 4;
    end else if (volume_level >= 100) begin
      digits[0] = 5'd1;
      digits[3] = GLYPH_PERCENT;
      count = 4;
    end else if (volume_level >= 10) begin
      digits[0] = 5'(volume_level / 10);
      digits[1] = 5'(volume_level % 10);
      digits[2] = GLYPH_PERCENT;
      count = 3;
    end else begin
      digits[0] = 5'(volume_level);
      digits[1] = GLYPH_PERCENT;
      count = 2;
    end
    if (glyph_hit(digits, count, (96 - (count * 18 - 3)) / 2, 55, 3, x, y)) return 1'b1;
    if (x >= 10 && x <= 85 && (y == 108 || y == 109 || y == 126 || y == 127)) return 1'b1;
    if (y >= 108 && y <= 127 && (x == 10 || x == 11 || x == 84 || x == 85)) return 1'b1;
    if (!muted && y >= 112 && y <= 123 && x >= 14 && x < 14 + (68 * volume_level) / 100)
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic volp_out_t shade(bit lit);
    volp_out_t res;
    res.pixel_lit = lit;
    res.pixel_colour = lit ? COLOUR_LIT : COLOUR_DARK;
    return res;
  endfunction

  function automatic int idle_chance();
    return quiet_stretch ? 0 : IDLE_PERCENT;
  endfunction

  task automatic send_pixel(logic [6:0] col, logic [7:0] row, volp_out_t result);
    pending_pixel_t entry;
    volp_in_t       coord;
    coord.pixel_column = col;
    coord.pixel_row = row;
    while ($urandom_range(99) < idle_chance()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= coord;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.coord = coord;
    entry.result = result;
    pending_pixels.push_back(entry);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == CFG_IDX_VOLUME) volume_level = value > PERCENT_MAX ? 100 : int'(value);
    else if (index == CFG_IDX_MUTE) muted = value[0];
    @(posedge clk);
  endtask

  function automatic logic [6:0] pick_volume();
    case ($urandom_range(5))
      0: return 7'($urandom_range(9));
      1: return 7'($urandom_range(99, 10));
      2: return PERCENT_MAX;
      3: return 7'($urandom_range(127, 101));
      4: begin
        case ($urandom_range(5))
          0: return 7'd0;
          1: return 7'd9;
          2: return 7'd10;
          3: return 7'd99;
          4: return 7'd100;
          default: return 7'd127;
        endcase
      end
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  task automatic random_pixel();
    int x;
    int y;
    int zone;
    zone = $urandom_range(99);
    if (zone < 20) begin
      x = $urandom_range(95);
      y = $urandom_range(29, 12);
    end else if (zone < 50) begin
      x = $urandom_range(95);
      y = $urandom_range(77, 53);
    end else if (zone < 75) begin
      x = $urandom_range(87, 8);
      y = $urandom_range(129, 106);
    end else if (zone < 92) begin
      x = $urandom_range(95);
      y = $urandom_range(159);
    end else begin
      x = $urandom_range(127);
      y = $urandom_range(255);
    end
    send_pixel(7'(x), 8'(y), shade(pixel_is_lit(x, y)));
  endtask

  always @(posedge clk) begin
    pending_pixel_t want;
    if (out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("Unexpected result: lit %0b colour %h", out_data.pixel_lit,
                   out_data.pixel_colour);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_lit !== want.result.pixel_lit ||
            out_data.pixel_colour !== want.result.pixel_colour) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Pixel (%0d,%0d): expected lit %0b colour %h, got lit %0b colour %h",
                     want.coord.pixel_column, want.coord.pixel_row,
                     want.result.pixel_lit, want.result.pixel_colour,
                     out_data.pixel_lit, out_data.pixel_colour);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < idle_chance());
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t step;
    volp_out_t result;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      step = DIRECTED[r];
      if (step.kind == ROW_WRITE) begin
        drain();
        write_reg(step.reg_index, step.reg_value);
      end else begin
        case (step.check)
          CHECK_DARK: result = shade(1'b0);
          CHECK_LIT: result = shade(1'b1);
          default: result = shade(pixel_is_lit(int'(step.col), int'(step.row)));
        endcase
        send_pixel(step.col, step.row, result);
      end
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain();
      quiet_stretch = phase >= 4 && phase < 7;
      if ($urandom_range(1)) begin
        write_reg(CFG_IDX_VOLUME, pick_volume());
        write_reg(CFG_IDX_MUTE, {6'($urandom_range(63)), $urandom_range(3) == 0});
      end else begin
        write_reg(CFG_IDX_MUTE, {6'($urandom_range(63)), $urandom_range(3) == 0});
        write_reg(CFG_IDX_VOLUME, pick_volume());
      end
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                  7'($urandom_range(127)));
      for (int n = 0; n < PIXELS_PER_PHASE; n++) random_pixel();
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
